>>> rtl/core/i2cram_pkg.sv
// ----------------------------------------------------------------------------
// I2C register access master: shared package
// Types, codes and constants used by the stages of the register access master.
// ----------------------------------------------------------------------------
package i2cram_pkg;

	// Item kinds on the input stream
	localparam logic KIND_TICK = 1'b0;
	localparam logic KIND_CMD  = 1'b1;

	// Transaction operations
	localparam logic [1:0] OP_READ_REG   = 2'd0;
	localparam logic [1:0] OP_READ_BLOCK = 2'd1;
	localparam logic [1:0] OP_WRITE_REG  = 2'd2;
	localparam logic [1:0] OP_NONE       = 2'd3;

	// Completion status codes
	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_NO_DEVICE  = 2'd1;
	localparam logic [1:0] ST_WRITE_NACK = 2'd2;

	// Configuration register indexes
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_STRETCH_LIMIT  = 1'b1;

	// Configuration reset values
	localparam logic [6:0] DEVICE_ADDRESS_RST = 7'h6D;
	localparam logic [7:0] STRETCH_LIMIT_RST  = 8'd200;

	// Bit sent first on the bus
	localparam logic [7:0] MSB_MASK = 8'h80;

	// Stream widths
	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 16;

	// Bus sequence phases, one half bit period each
	typedef enum logic [3:0] {
		PH_IDLE,
		PH_START_A,
		PH_START_B,
		PH_START_C,
		PH_TX_LOW,
		PH_TX_HIGH,
		PH_ACK_LOW,
		PH_ACK_HIGH,
		PH_RX_LOW,
		PH_RX_HIGH,
		PH_MACK_LOW,
		PH_MACK_HIGH,
		PH_STOP_A,
		PH_STOP_B
	} phase_t;

	// Which byte of the transaction is on the bus
	typedef enum logic [2:0] {
		STG_ADDR_W,
		STG_REG,
		STG_ADDR_R,
		STG_DATA_W,
		STG_ABSENT
	} stage_t;

	// One input item
	typedef struct packed {
		logic       kind;
		logic [1:0] operation;
		logic [7:0] register_index;
		logic [7:0] write_value;
		logic [4:0] byte_count;
		logic       scl_sample;
		logic       sda_sample;
	} item_t;

	// One result item
	typedef struct packed {
		logic       scl_drive_low;
		logic       sda_drive_low;
		logic       byte_valid;
		logic [7:0] read_byte;
		logic       last_byte;
		logic       done_res;
		logic [1:0] status;
		logic       busy_res;
	} result_t;

	// Configuration write
	typedef struct packed {
		logic                  we;
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_wr_t;

endpackage

>>> rtl/core/i2cram_in_reg.sv
// ----------------------------------------------------------------------------
// I2C register access master: input register
// Captures one input transfer and holds it until the sequencer takes it.
// ----------------------------------------------------------------------------
module i2cram_in_reg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// s_tdata: operation[1:0], register_index[9:2], write_value[17:10],
	// byte_count[22:18], scl_sample[23], sda_sample[24], zeros above
	input  logic [i2cram_pkg::S_TDATA_W-1:0]    s_tdata,
	// s_tuser: kind
	input  logic                                s_tuser,
	input  logic                                advance,
	output logic                                valid_s1,
	output i2cram_pkg::item_t                   item_s1
);

	logic take;

	// Room when empty or whenever the held item leaves in the same cycle
	assign s_tready = !valid_s1 || advance;
	assign take     = s_tvalid && s_tready;

	// Occupancy of the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload unpacked from the stream fields
	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.kind           <= s_tuser;
			item_s1.operation      <= s_tdata[1:0];
			item_s1.register_index <= s_tdata[9:2];
			item_s1.write_value    <= s_tdata[17:10];
			item_s1.byte_count     <= s_tdata[22:18];
			item_s1.scl_sample     <= s_tdata[23];
			item_s1.sda_sample     <= s_tdata[24];
		end
	end

endmodule

>>> rtl/core/i2cram_fsm.sv
// ----------------------------------------------------------------------------
// I2C register access master: bus sequencer
// Holds the configuration and the transaction state and takes one step per item.
// ----------------------------------------------------------------------------
module i2cram_fsm #(
	parameter int MAX_BLOCK = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  i2cram_pkg::cfg_wr_t   cfg,
	input  logic                  advance,
	input  i2cram_pkg::item_t     item,
	output i2cram_pkg::result_t   res
);

	localparam int BL_W = $clog2(MAX_BLOCK + 1);

	// Configuration registers
	logic [6:0] dev_addr_q;
	logic [7:0] stretch_lim_q;

	// Transaction state
	i2cram_pkg::phase_t phase_q, phase_d;
	i2cram_pkg::stage_t stage_q, stage_d;
	logic [3:0]      bit_cnt_q, bit_cnt_d;
	logic [7:0]      shift_q, shift_d;
	logic [BL_W-1:0] left_q, left_d;
	logic [7:0]      stretch_q, stretch_d;
	logic [1:0]      op_q, op_d;
	logic [7:0]      reg_q, reg_d;
	logic [7:0]      val_q, val_d;
	logic            wok_q, wok_d;

	logic            proceed;
	logic            ack;
	logic [3:0]      bit_inc;
	logic [BL_W-1:0] left_dec;
	logic [BL_W-1:0] blk_len;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q    <= i2cram_pkg::DEVICE_ADDRESS_RST;
			stretch_lim_q <= i2cram_pkg::STRETCH_LIMIT_RST;
		end else if (cfg.we) begin
			unique case (cfg.index)
				i2cram_pkg::CFG_DEVICE_ADDRESS: dev_addr_q    <= cfg.data[6:0];
				i2cram_pkg::CFG_STRETCH_LIMIT:  stretch_lim_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// State registers, stepped once per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= i2cram_pkg::PH_IDLE;
			stage_q   <= i2cram_pkg::STG_ADDR_W;
			bit_cnt_q <= '0;
			shift_q   <= '0;
			left_q    <= '0;
			stretch_q <= '0;
			op_q      <= '0;
			reg_q     <= '0;
			val_q     <= '0;
			wok_q     <= 1'b1;
		end else if (advance) begin
			phase_q   <= phase_d;
			stage_q   <= stage_d;
			bit_cnt_q <= bit_cnt_d;
			shift_q   <= shift_d;
			left_q    <= left_d;
			stretch_q <= stretch_d;
			op_q      <= op_d;
			reg_q     <= reg_d;
			val_q     <= val_d;
			wok_q     <= wok_d;
		end
	end

	// Helpers: stretch check, acknowledge, counters and block length
	assign proceed  = !(!item.scl_sample && (stretch_q < stretch_lim_q));
	assign ack      = !item.sda_sample;
	assign bit_inc  = bit_cnt_q + 4'd1;
	assign left_dec = (left_q != '0) ? left_q - BL_W'(1) : left_q;

	always_comb begin
		if (item.byte_count == 5'd0) begin
			blk_len = BL_W'(1);
		end else if (int'(item.byte_count) > MAX_BLOCK) begin
			blk_len = BL_W'(MAX_BLOCK);
		end else begin
			blk_len = BL_W'(item.byte_count);
		end
	end

	// Next state and result for one item
	always_comb begin
		phase_d   = phase_q;
		stage_d   = stage_q;
		bit_cnt_d = bit_cnt_q;
		shift_d   = shift_q;
		left_d    = left_q;
		stretch_d = stretch_q;
		op_d      = op_q;
		reg_d     = reg_q;
		val_d     = val_q;
		wok_d     = wok_q;
		res       = '0;

		if (item.kind == i2cram_pkg::KIND_CMD) begin
			// A command starts a transaction only from idle
			if (phase_q == i2cram_pkg::PH_IDLE && item.operation != i2cram_pkg::OP_NONE) begin
				op_d      = item.operation;
				reg_d     = item.register_index;
				val_d     = item.write_value;
				left_d    = (item.operation == i2cram_pkg::OP_READ_BLOCK) ?
				            blk_len : BL_W'(1);
				wok_d     = 1'b1;
				stage_d   = i2cram_pkg::STG_ADDR_W;
				bit_cnt_d = '0;
				shift_d   = '0;
				stretch_d = '0;
				phase_d   = i2cram_pkg::PH_START_A;
			end
		end else begin
			// Phases with SCL released wait for it, up to the stretch limit
			if (phase_q == i2cram_pkg::PH_START_A || phase_q == i2cram_pkg::PH_TX_HIGH ||
			    phase_q == i2cram_pkg::PH_ACK_HIGH || phase_q == i2cram_pkg::PH_RX_HIGH ||
			    phase_q == i2cram_pkg::PH_MACK_HIGH || phase_q == i2cram_pkg::PH_STOP_B) begin
				stretch_d = proceed ? 8'd0 : stretch_q + 8'd1;
			end

			unique case (phase_q)
				i2cram_pkg::PH_START_A: begin
					if (proceed) phase_d = i2cram_pkg::PH_START_B;
				end
				i2cram_pkg::PH_START_B: phase_d = i2cram_pkg::PH_START_C;
				i2cram_pkg::PH_START_C: begin
					shift_d   = {dev_addr_q, (stage_q == i2cram_pkg::STG_ADDR_R)};
					bit_cnt_d = '0;
					phase_d   = i2cram_pkg::PH_TX_LOW;
				end
				i2cram_pkg::PH_TX_LOW: phase_d = i2cram_pkg::PH_TX_HIGH;
				i2cram_pkg::PH_TX_HIGH: begin
					if (proceed) begin
						shift_d   = {shift_q[6:0], 1'b0};
						bit_cnt_d = bit_inc;
						phase_d   = (bit_inc >= 4'd8) ? i2cram_pkg::PH_ACK_LOW :
						            i2cram_pkg::PH_TX_LOW;
					end
				end
				i2cram_pkg::PH_ACK_LOW: phase_d = i2cram_pkg::PH_ACK_HIGH;
				i2cram_pkg::PH_ACK_HIGH: begin
					if (proceed) begin
						unique case (stage_q)
							i2cram_pkg::STG_ADDR_W: begin
								if (!ack) begin
									stage_d = i2cram_pkg::STG_ABSENT;
									phase_d = i2cram_pkg::PH_STOP_A;
								end else begin
									stage_d   = i2cram_pkg::STG_REG;
									shift_d   = reg_q;
									bit_cnt_d = '0;
									phase_d   = i2cram_pkg::PH_TX_LOW;
								end
							end
							i2cram_pkg::STG_REG: begin
								if (op_q == i2cram_pkg::OP_WRITE_REG) begin
									if (!ack) begin
										wok_d   = 1'b0;
										phase_d = i2cram_pkg::PH_STOP_A;
									end else begin
										stage_d   = i2cram_pkg::STG_DATA_W;
										shift_d   = val_q;
										bit_cnt_d = '0;
										phase_d   = i2cram_pkg::PH_TX_LOW;
									end
								end else begin
									// Register byte NACK in a read is ignored
									stage_d = i2cram_pkg::STG_ADDR_R;
									phase_d = i2cram_pkg::PH_START_A;
								end
							end
							i2cram_pkg::STG_ADDR_R: begin
								if (!ack) begin
									stage_d = i2cram_pkg::STG_ABSENT;
									phase_d = i2cram_pkg::PH_STOP_A;
								end else begin
									shift_d   = '0;
									bit_cnt_d = '0;
									phase_d   = i2cram_pkg::PH_RX_LOW;
								end
							end
							default: begin
								if (!ack) wok_d = 1'b0;
								phase_d = i2cram_pkg::PH_STOP_A;
							end
						endcase
					end
				end
				i2cram_pkg::PH_RX_LOW: phase_d = i2cram_pkg::PH_RX_HIGH;
				i2cram_pkg::PH_RX_HIGH: begin
					if (proceed) begin
						shift_d   = {shift_q[6:0], item.sda_sample};
						bit_cnt_d = bit_inc;
						phase_d   = (bit_inc >= 4'd8) ? i2cram_pkg::PH_MACK_LOW :
						            i2cram_pkg::PH_RX_LOW;
					end
				end
				i2cram_pkg::PH_MACK_LOW: phase_d = i2cram_pkg::PH_MACK_HIGH;
				i2cram_pkg::PH_MACK_HIGH: begin
					if (proceed) begin
						res.byte_valid = 1'b1;
						res.read_byte  = shift_q;
						res.last_byte  = (left_q <= BL_W'(1));
						left_d         = left_dec;
						if (left_dec != '0) begin
							shift_d   = '0;
							bit_cnt_d = '0;
							phase_d   = i2cram_pkg::PH_RX_LOW;
						end else begin
							phase_d = i2cram_pkg::PH_STOP_A;
						end
					end
				end
				i2cram_pkg::PH_STOP_A: phase_d = i2cram_pkg::PH_STOP_B;
				i2cram_pkg::PH_STOP_B: begin
					if (proceed) begin
						res.done_res = 1'b1;
						if (stage_q == i2cram_pkg::STG_ABSENT) begin
							res.status = i2cram_pkg::ST_NO_DEVICE;
						end else if (wok_q) begin
							res.status = i2cram_pkg::ST_OK;
						end else begin
							res.status = i2cram_pkg::ST_WRITE_NACK;
						end
						phase_d = i2cram_pkg::PH_IDLE;
					end
				end
				default: phase_d = i2cram_pkg::PH_IDLE;
			endcase
		end

		// Line drives follow the phase reached
		unique case (phase_d)
			i2cram_pkg::PH_START_B: res.sda_drive_low = 1'b1;
			i2cram_pkg::PH_START_C: begin
				res.scl_drive_low = 1'b1;
				res.sda_drive_low = 1'b1;
			end
			i2cram_pkg::PH_TX_LOW: begin
				res.scl_drive_low = 1'b1;
				res.sda_drive_low = ((shift_d & i2cram_pkg::MSB_MASK) == 8'd0);
			end
			i2cram_pkg::PH_TX_HIGH:
				res.sda_drive_low = ((shift_d & i2cram_pkg::MSB_MASK) == 8'd0);
			i2cram_pkg::PH_ACK_LOW, i2cram_pkg::PH_RX_LOW: res.scl_drive_low = 1'b1;
			i2cram_pkg::PH_MACK_LOW: begin
				res.scl_drive_low = 1'b1;
				res.sda_drive_low = (left_d > BL_W'(1));
			end
			i2cram_pkg::PH_MACK_HIGH: res.sda_drive_low = (left_d > BL_W'(1));
			i2cram_pkg::PH_STOP_A: begin
				res.scl_drive_low = 1'b1;
				res.sda_drive_low = 1'b1;
			end
			i2cram_pkg::PH_STOP_B: res.sda_drive_low = 1'b1;
			default: ;
		endcase

		res.busy_res = (phase_d != i2cram_pkg::PH_IDLE);
	end

	// The stretch count is cleared whenever the master sits idle
	a_idle_no_stretch: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == i2cram_pkg::PH_IDLE |-> stretch_q == 8'd0)
		else $error("stretch count left over in idle");

	// A non-zero status only appears with the stop condition
	a_status_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		res.status != i2cram_pkg::ST_OK |-> res.done_res && !res.busy_res)
		else $error("status outside completion");

	// A presented byte leads to the next byte or to the stop condition
	a_byte_next: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res.byte_valid |=>
		phase_q == i2cram_pkg::PH_RX_LOW || phase_q == i2cram_pkg::PH_STOP_A)
		else $error("unexpected phase after received byte");

	// The last marker only comes with a received byte
	a_last_with_byte: assert property (@(posedge clk) disable iff (!arst_n)
		res.last_byte |-> res.byte_valid)
		else $error("last marker without byte");

endmodule

>>> rtl/core/i2cram_out_reg.sv
// ----------------------------------------------------------------------------
// I2C register access master: result register
// Holds one result transfer until the downstream side takes it.
// ----------------------------------------------------------------------------
module i2cram_out_reg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  i2cram_pkg::result_t               res,
	input  logic                              advance,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// m_tdata: scl_drive_low[0], sda_drive_low[1], read_byte[9:2], done_res[10],
	// status[12:11], busy_res[13], zeros above
	output logic [i2cram_pkg::M_TDATA_W-1:0]  m_tdata,
	// m_tuser: byte_valid
	output logic                              m_tuser,
	output logic                              m_tlast,
	output logic                              free
);

	i2cram_pkg::result_t res_q;

	// Space for a new result when empty or when the held one leaves now
	assign free = !m_tvalid || m_tready;

	// Occupancy of the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	// Stream packing
	assign m_tdata = {2'b00, res_q.busy_res, res_q.status, res_q.done_res,
	                  res_q.read_byte, res_q.sda_drive_low, res_q.scl_drive_low};
	assign m_tuser = res_q.byte_valid;
	assign m_tlast = res_q.last_byte;

endmodule

>>> rtl/core/i2c_register_access_master.sv
// Each item is held in the input register, then its result in the result register.
// Throughput: one item per cycle when not stalled; one sequencer step per item.
// A stalled result register holds off the input side once the input register is full.
// Reset (arst_n low) idles the bus with both lines released and restores the
// device address 0x6D and the stretch limit of 200 ticks.
// ----------------------------------------------------------------------------
// I2C register access master: top level
// Open-drain master that reads one register, a block of registers, or writes one.
// ----------------------------------------------------------------------------
module i2c_register_access_master #(
	parameter int MAX_BLOCK = 16
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_we,
	input  logic [i2cram_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [i2cram_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                    s_tvalid,
	output logic                                    s_tready,
	// s_tdata: operation[1:0], register_index[9:2], write_value[17:10],
	// byte_count[22:18], scl_sample[23], sda_sample[24], zeros above
	input  logic [i2cram_pkg::S_TDATA_W-1:0]        s_tdata,
	// s_tuser: kind
	input  logic                                    s_tuser,
	output logic                                    m_tvalid,
	input  logic                                    m_tready,
	// m_tdata: scl_drive_low[0], sda_drive_low[1], read_byte[9:2], done_res[10],
	// status[12:11], busy_res[13], zeros above
	output logic [i2cram_pkg::M_TDATA_W-1:0]        m_tdata,
	// m_tuser: byte_valid
	output logic                                    m_tuser,
	output logic                                    m_tlast
);

	logic                valid_s1;
	i2cram_pkg::item_t   item_s1;
	i2cram_pkg::result_t res;
	i2cram_pkg::cfg_wr_t cfg;
	logic                free;
	logic                advance;

	// Configuration write bundle
	assign cfg.we    = cfg_we;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	// One step whenever an item is held and the result register has room
	assign advance = valid_s1 && free;

	i2cram_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	i2cram_fsm #(
		.MAX_BLOCK (MAX_BLOCK)
	) u_fsm (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.advance (advance),
		.item    (item_s1),
		.res     (res)
	);

	i2cram_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.res      (res),
		.advance  (advance),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.free     (free)
	);

	// With the result register empty the input side is never held off
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty result register");

	// A step always leaves a result in the register
	a_step_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_tvalid)
		else $error("step without result");

	// A held item is never dropped while the output is blocked
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && m_tvalid && !m_tready |=> valid_s1)
		else $error("input item lost under stall");

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C register access master: testbench
// Drives commands and half-bit ticks into the master. A small device model
// answers on the sampled SCL and SDA lines with acknowledges, data bits and
// clock stretching. A cycle-free predictor in the bench computes the result of
// every transfer, and each result from the master is checked field by field.
// ----------------------------------------------------------------------------
module tb;
	import i2cram_pkg::*;

	localparam int MAX_BLOCK = 16;
	localparam int TICKS_PER_SETTING = 20;

	// Ports of the master
	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata   = '0;
	logic                  s_tuser   = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic                  m_tuser;
	logic                  m_tlast;

	// Items waiting to be sent, and the results they will cause
	item_t   bus_items_todo[$];
	result_t bus_results_due[$];

	// Predictor copy of the configuration and the sequencer state
	logic [6:0] cfg_addr;
	logic [7:0] cfg_limit;
	phase_t     bus_phase;
	stage_t     bus_stage;
	logic [3:0] bit_cnt;
	logic [7:0] shreg;
	logic [4:0] bytes_left;
	logic [7:0] stretch_cnt;
	logic [1:0] op_held;
	logic [7:0] reg_held;
	logic [7:0] val_held;
	logic       wr_ok;

	// Behaviour of the emulated device on the bus
	bit dev_absent;
	bit dev_nack_reg;
	bit dev_nack_data;
	bit dev_nack_raddr;
	int stretch_left;
	int stretch_pct;
	int noise_pct;
	int junk_pct;

	// Flow control and bookkeeping
	bit idling = 1'b1;
	int gap_left = 0;
	int stall_left = 0;
	int errors = 0;
	int n_checked = 0;
	int n_xact = 0;
	int n_bytes = 0;
	int n_ok = 0;
	int n_absent = 0;
	int n_wnack = 0;
	int n_ticks = 0;

	i2c_register_access_master #(.MAX_BLOCK(MAX_BLOCK)) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	// Clock and a single reset at the start
	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Hard limit on the run time
	initial begin
		#3_000_000;
		$display("tb NOT OK");
		$finish;
	end

	// Line drives for the current phase, {sda, scl}
	function automatic logic [1:0] line_drives();
		logic c;
		logic d;
		c = 1'b0;
		d = 1'b0;
		case (bus_phase)
			PH_START_B:   d = 1'b1;
			PH_START_C:   begin c = 1'b1; d = 1'b1; end
			PH_TX_LOW:    begin c = 1'b1; d = ((shreg & MSB_MASK) == 0); end
			PH_TX_HIGH:   d = ((shreg & MSB_MASK) == 0);
			PH_ACK_LOW:   c = 1'b1;
			PH_RX_LOW:    c = 1'b1;
			PH_MACK_LOW:  begin c = 1'b1; d = (bytes_left > 1); end
			PH_MACK_HIGH: d = (bytes_left > 1);
			PH_STOP_A:    begin c = 1'b1; d = 1'b1; end
			PH_STOP_B:    d = 1'b1;
			default:      ;
		endcase
		return {d, c};
	endfunction

	// A released SCL phase waits while SCL reads low, up to the stretch limit
	function automatic logic scl_released(input logic scl);
		if (!scl && stretch_cnt < cfg_limit) begin
			stretch_cnt++;
			return 1'b0;
		end
		stretch_cnt = '0;
		return 1'b1;
	endfunction

	function automatic void load_tx(input logic [7:0] b);
		shreg = b;
		bit_cnt = '0;
		bus_phase = PH_TX_LOW;
	endfunction

	// Decide where the transaction goes once an acknowledge slot is sampled
	function automatic void take_ack(input logic ack);
		case (bus_stage)
			STG_ADDR_W: begin
				if (!ack) begin
					bus_stage = STG_ABSENT;
					bus_phase = PH_STOP_A;
				end else begin
					bus_stage = STG_REG;
					load_tx(reg_held);
				end
			end
			STG_REG: begin
				if (op_held == OP_WRITE_REG) begin
					if (!ack) begin
						wr_ok = 1'b0;
						bus_phase = PH_STOP_A;
					end else begin
						bus_stage = STG_DATA_W;
						load_tx(val_held);
					end
				end else begin
					bus_stage = STG_ADDR_R;
					bus_phase = PH_START_A;
				end
			end
			STG_ADDR_R: begin
				if (!ack) begin
					bus_stage = STG_ABSENT;
					bus_phase = PH_STOP_A;
				end else begin
					shreg = '0;
					bit_cnt = '0;
					bus_phase = PH_RX_LOW;
				end
			end
			default: begin
				if (!ack)
					wr_ok = 1'b0;
				bus_phase = PH_STOP_A;
			end
		endcase
	endfunction

	// Predict the result of one input transfer and advance the sequencer copy
	function automatic result_t predict_bus_step(input item_t it);
		result_t    r;
		logic [1:0] dr;
		logic [4:0] n;
		r = '0;
		if (it.kind == KIND_CMD) begin
			if (bus_phase == PH_IDLE &&
					it.operation inside {OP_READ_REG, OP_READ_BLOCK, OP_WRITE_REG}) begin
				n = it.byte_count;
				if (n == 5'd0)
					n = 5'd1;
				if (n > MAX_BLOCK)
					n = 5'(MAX_BLOCK);
				op_held = it.operation;
				reg_held = it.register_index;
				val_held = it.write_value;
				bytes_left = (it.operation == OP_READ_BLOCK) ? n : 5'd1;
				wr_ok = 1'b1;
				bus_stage = STG_ADDR_W;
				bit_cnt = '0;
				shreg = '0;
				stretch_cnt = '0;
				bus_phase = PH_START_A;
				n_xact++;
			end
		end else begin
			case (bus_phase)
				PH_START_A: begin
					if (scl_released(it.scl_sample))
						bus_phase = PH_START_B;
				end
				PH_START_B: bus_phase = PH_START_C;
				PH_START_C: load_tx({cfg_addr, bus_stage == STG_ADDR_R});
				PH_TX_LOW:  bus_phase = PH_TX_HIGH;
				PH_TX_HIGH: begin
					if (scl_released(it.scl_sample)) begin
						shreg = shreg << 1;
						bit_cnt++;
						bus_phase = (bit_cnt >= 8) ? PH_ACK_LOW : PH_TX_LOW;
					end
				end
				PH_ACK_LOW: bus_phase = PH_ACK_HIGH;
				PH_ACK_HIGH: begin
					if (scl_released(it.scl_sample))
						take_ack(it.sda_sample == 1'b0);
				end
				PH_RX_LOW: bus_phase = PH_RX_HIGH;
				PH_RX_HIGH: begin
					if (scl_released(it.scl_sample)) begin
						shreg = {shreg[6:0], it.sda_sample};
						bit_cnt++;
						bus_phase = (bit_cnt >= 8) ? PH_MACK_LOW : PH_RX_LOW;
					end
				end
				PH_MACK_LOW: bus_phase = PH_MACK_HIGH;
				PH_MACK_HIGH: begin
					if (scl_released(it.scl_sample)) begin
						r.byte_valid = 1'b1;
						r.read_byte = shreg;
						r.last_byte = (bytes_left <= 1);
						n_bytes++;
						if (bytes_left > 0)
							bytes_left--;
						if (bytes_left > 0) begin
							shreg = '0;
							bit_cnt = '0;
							bus_phase = PH_RX_LOW;
						end else begin
							bus_phase = PH_STOP_A;
						end
					end
				end
				PH_STOP_A: bus_phase = PH_STOP_B;
				PH_STOP_B: begin
					if (scl_released(it.scl_sample)) begin
						r.done_res = 1'b1;
						if (bus_stage == STG_ABSENT) begin
							r.status = ST_NO_DEVICE;
							n_absent++;
						end else if (wr_ok) begin
							r.status = ST_OK;
							n_ok++;
						end else begin
							r.status = ST_WRITE_NACK;
							n_wnack++;
						end
						bus_phase = PH_IDLE;
					end
				end
				default: bus_phase = PH_IDLE;
			endcase
		end
		dr = line_drives();
		r.scl_drive_low = dr[0];
		r.sda_drive_low = dr[1];
		r.busy_res = (bus_phase != PH_IDLE);
		return r;
	endfunction

	// One tick as the emulated device would sample the lines on it
	function automatic item_t bus_tick();
		item_t      it;
		logic [1:0] dr;
		logic       pull;
		dr = line_drives();
		it.kind = KIND_TICK;
		it.operation = $urandom_range(0, 3);
		it.register_index = $urandom_range(0, 255);
		it.write_value = $urandom_range(0, 255);
		it.byte_count = $urandom_range(0, 31);
		// SCL low when the master pulls it, or while the device stretches.
		// Stretches beyond the limit are only made where the limit is short.
		if (dr[0]) begin
			it.scl_sample = 1'b0;
		end else begin
			if (stretch_left == 0 && bus_phase != PH_IDLE && $urandom_range(0, 99) < stretch_pct)
				stretch_left = (cfg_limit <= 8'd30 && $urandom_range(0, 9) == 0) ?
					cfg_limit + $urandom_range(1, 3) : $urandom_range(1, 4);
			if (stretch_left > 0) begin
				it.scl_sample = 1'b0;
				stretch_left--;
			end else begin
				it.scl_sample = 1'b1;
			end
		end
		// Device answers in the acknowledge slot and shifts out random data
		pull = 1'b0;
		if (bus_phase == PH_ACK_HIGH) begin
			case (bus_stage)
				STG_ADDR_W: pull = !dev_absent;
				STG_REG:    pull = !dev_nack_reg;
				STG_ADDR_R: pull = !dev_nack_raddr;
				default:    pull = !dev_nack_data;
			endcase
		end else if (bus_phase == PH_RX_HIGH) begin
			pull = $urandom_range(0, 1);
		end
		it.sda_sample = !(dr[1] || pull);
		if ($urandom_range(0, 99) < noise_pct)
			it.scl_sample = $urandom_range(0, 1);
		if ($urandom_range(0, 99) < noise_pct)
			it.sda_sample = $urandom_range(0, 1);
		return it;
	endfunction

	function automatic item_t command_item(input logic [1:0] op, input logic [7:0] ri,
			input logic [7:0] wv, input logic [4:0] cnt);
		item_t it;
		it.kind = KIND_CMD;
		it.operation = op;
		it.register_index = ri;
		it.write_value = wv;
		it.byte_count = cnt;
		it.scl_sample = $urandom_range(0, 1);
		it.sda_sample = $urandom_range(0, 1);
		return it;
	endfunction

	task automatic issue(input item_t it);
		bus_items_todo.push_back(it);
		bus_results_due.push_back(predict_bus_step(it));
	endtask

	task automatic set_device(input bit absent, input bit nreg, input bit ndata, input bit nraddr);
		dev_absent = absent;
		dev_nack_reg = nreg;
		dev_nack_data = ndata;
		dev_nack_raddr = nraddr;
	endtask

	// A command followed by ticks until the bus is idle again
	task automatic run_transaction(input logic [1:0] op, input logic [7:0] ri,
			input logic [7:0] wv, input logic [4:0] cnt);
		issue(command_item(op, ri, wv, cnt));
		while (bus_phase != PH_IDLE) begin
			if ($urandom_range(0, 99) < junk_pct)
				issue(command_item($urandom_range(0, 3), $urandom_range(0, 255),
					$urandom_range(0, 255), $urandom_range(0, 31)));
			issue(bus_tick());
			n_ticks++;
		end
	endtask

	task automatic random_transaction();
		int         pick;
		logic [1:0] op;
		logic [4:0] cnt;
		pick = $urandom_range(0, 99);
		if (pick < 3)
			op = OP_NONE;
		else if (pick < 35)
			op = OP_READ_REG;
		else if (pick < 70)
			op = OP_READ_BLOCK;
		else
			op = OP_WRITE_REG;
		// Mostly short blocks, a few long or out of range
		pick = $urandom_range(0, 99);
		if (pick < 75)
			cnt = $urandom_range(1, 4);
		else if (pick < 88)
			cnt = $urandom_range(5, MAX_BLOCK);
		else if (pick < 94)
			cnt = '0;
		else
			cnt = $urandom_range(MAX_BLOCK + 1, 31);
		set_device($urandom_range(0, 99) < 10, $urandom_range(0, 99) < 15,
			$urandom_range(0, 99) < 15, $urandom_range(0, 99) < 8);
		if ($urandom_range(0, 9) == 0)
			repeat ($urandom_range(1, 3)) issue(bus_tick());
		run_transaction(op, $urandom_range(0, 255), $urandom_range(0, 255), cnt);
	endtask

	// Wait until every item is sent and every result has come back
	task automatic drain();
		while (bus_items_todo.size() != 0 || bus_results_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_DEVICE_ADDRESS)
			cfg_addr = value[6:0];
		else
			cfg_limit = value;
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			errors++;
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	// Stimulus: directed transactions, then random ones under several settings
	initial begin
		int addr_val;
		int limit_val;
		cfg_addr = DEVICE_ADDRESS_RST;
		cfg_limit = STRETCH_LIMIT_RST;
		bus_phase = PH_IDLE;
		bus_stage = STG_ADDR_W;
		bit_cnt = '0;
		shreg = '0;
		bytes_left = '0;
		stretch_cnt = '0;
		op_held = '0;
		reg_held = '0;
		val_held = '0;
		wr_ok = 1'b1;
		stretch_left = 0;
		stretch_pct = 0;
		noise_pct = 0;
		junk_pct = 0;
		set_device(1'b0, 1'b0, 1'b0, 1'b0);

		// Directed part at the reset configuration
		issue(bus_tick());
		run_transaction(OP_READ_REG, 8'h00, 8'h00, 5'd1);
		run_transaction(OP_READ_BLOCK, 8'hFF, 8'hFF, 5'd0);
		run_transaction(OP_READ_BLOCK, 8'h5A, 8'h00, 5'd31);
		run_transaction(OP_WRITE_REG, 8'hFF, 8'hFF, 5'd16);
		run_transaction(OP_WRITE_REG, 8'h00, 8'h00, 5'd1);
		run_transaction(OP_NONE, 8'hA5, 8'h5A, 5'd3);
		// Commands arriving while busy are dropped
		junk_pct = 30;
		run_transaction(OP_READ_REG, 8'h12, 8'h34, 5'd2);
		junk_pct = 0;
		// Device absent on the address byte
		set_device(1'b1, 1'b0, 1'b0, 1'b0);
		run_transaction(OP_READ_REG, 8'h01, 8'h00, 5'd1);
		run_transaction(OP_WRITE_REG, 8'h02, 8'hC3, 5'd1);
		// Register byte refused: carried on in a read, aborts a write
		set_device(1'b0, 1'b1, 1'b0, 1'b0);
		run_transaction(OP_READ_REG, 8'h03, 8'h00, 5'd1);
		run_transaction(OP_WRITE_REG, 8'h04, 8'h3C, 5'd1);
		// Data byte refused in a write, read address refused in a block read
		set_device(1'b0, 1'b0, 1'b1, 1'b0);
		run_transaction(OP_WRITE_REG, 8'h05, 8'h81, 5'd1);
		set_device(1'b0, 1'b0, 1'b0, 1'b1);
		run_transaction(OP_READ_BLOCK, 8'h06, 8'h00, 5'd3);
		// Heavy stretching within the limit
		set_device(1'b0, 1'b0, 1'b0, 1'b0);
		stretch_pct = 30;
		run_transaction(OP_READ_BLOCK, 8'h07, 8'h00, 5'd2);

		// Random part, one block per configuration
		stretch_pct = 3;
		noise_pct = 2;
		junk_pct = 2;
		for (int setting = 1; setting <= 5; setting++) begin
			drain();
			case (setting)
				1: begin addr_val = 0; limit_val = 1; end
				2: begin addr_val = 127; limit_val = 255; end
				3: begin addr_val = $urandom_range(0, 127); limit_val = 0; end
				4: begin addr_val = $urandom_range(0, 127); limit_val = $urandom_range(2, 30); end
				default: begin
					addr_val = $urandom_range(0, 127);
					limit_val = $urandom_range(1, 255);
				end
			endcase
			write_cfg(CFG_DEVICE_ADDRESS, addr_val);
			write_cfg(CFG_STRETCH_LIMIT, limit_val);
			idling = (setting != 5);
			n_ticks = 0;
			while (n_ticks < TICKS_PER_SETTING)
				random_transaction();
		end

		drain();
		repeat (10) @(posedge clk);
		$display("Covered %0d transactions: %0d ok, %0d without a device, %0d refused writes.",
			n_xact, n_ok, n_absent, n_wnack);
		$display("Checked %0d results, %0d of them with a read byte, over six bus settings.",
			n_checked, n_bytes);
		if (errors == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

	// Sender: one item per transfer, with random gaps
	always @(posedge clk) begin
		item_t it;
		if (arst_n && (!s_tvalid || s_tready)) begin
			if (gap_left > 0) begin
				s_tvalid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (bus_items_todo.size() == 0) begin
				s_tvalid <= 1'b0;
			end else if (idling && $urandom_range(0, 9) == 0) begin
				s_tvalid <= 1'b0;
				gap_left <= $urandom_range(0, 12);
			end else begin
				it = bus_items_todo.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= it.kind;
				s_tdata <= {7'd0, it.sda_sample, it.scl_sample, it.byte_count,
					it.write_value, it.register_index, it.operation};
			end
		end
	end

	// Receiver: check each result transfer, stall at random
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.scl_drive_low = m_tdata[0];
				got.sda_drive_low = m_tdata[1];
				got.read_byte = m_tdata[9:2];
				got.done_res = m_tdata[10];
				got.status = m_tdata[12:11];
				got.busy_res = m_tdata[13];
				got.byte_valid = m_tuser;
				got.last_byte = m_tlast;
				if (bus_results_due.size() == 0) begin
					errors++;
					$display("%0t: result %h with nothing expected", $time, m_tdata);
				end else begin
					want = bus_results_due.pop_front();
					n_checked++;
					check_field("scl_drive_low", want.scl_drive_low, got.scl_drive_low);
					check_field("sda_drive_low", want.sda_drive_low, got.sda_drive_low);
					check_field("byte_valid", want.byte_valid, got.byte_valid);
					check_field("read_byte", want.read_byte, got.read_byte);
					check_field("last_byte", want.last_byte, got.last_byte);
					check_field("done_res", want.done_res, got.done_res);
					check_field("status", want.status, got.status);
					check_field("busy_res", want.busy_res, got.busy_res);
				end
			end
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left <= stall_left - 1;
			end else if (idling && $urandom_range(0, 9) == 0) begin
				m_tready <= 1'b0;
				stall_left <= $urandom_range(0, 12);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

endmodule
